FILE: hdl/rhts_pkg.sv
// ----------------------------------------------------------------------------
// rhts_pkg - shared definitions for the humidity/temperature sensor readout
// Event codes, pending-measurement codes, conversion constants, the frame
// checksum function and the stage types used by the readout sequencer.
// ----------------------------------------------------------------------------
package rhts_pkg;

   // event codes carried on the request channel
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_POLL  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // pending measurement codes
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_TEMP = 2'd1;
   localparam logic [1:0] PEND_HUM  = 2'd2;

   // measurement kinds
   localparam logic KIND_TEMP = 1'b0;

   // checksum: x^8+x^5+x^4+1, init 0, MSB first
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [15:0] STATUS_MASK = 16'h0003;

   // conversion: scaled product rounded to nearest, then offset removed
   localparam logic [14:0] TEMP_SCALE  = 15'd17572;
   localparam logic [13:0] HUM_SCALE   = 14'd12500;
   localparam logic [30:0] ROUND_HALF  = 31'd32768;
   localparam logic [14:0] TEMP_OFFSET = 15'd4685;
   localparam logic [14:0] HUM_OFFSET  = 15'd600;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

   // registered request after checksum and scaling
   typedef struct packed {
      logic [1:0]  opcode;
      logic        kind;
      logic        read_ok;
      logic        crc_ok;
      logic [14:0] temp_val;
      logic [14:0] hum_val;
   } stage_type;

   // result flags
   typedef struct packed {
      logic command_issued;
      logic command_kind;
      logic value_ready;
      logic crc_error;
      logic timed_out;
   } flags_type;

   // CRC-8 over the two data bytes; bit-serial XOR network, linear in its input
   function automatic logic [7:0] crc8_frame(input logic [15:0] data);
      logic [7:0] crc;
      crc = 8'h00;
      for (int i = 15; i >= 0; i--) begin
         if (crc[7] ^ data[i]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

FILE: hdl/rh_temp_sensor_readout.sv
// ----------------------------------------------------------------------------
// rh_temp_sensor_readout - readout sequencer for a humidity/temperature sensor
// A request is taken into the input register and its result beat is then held
// in the result register. Throughput: one beat per cycle while the result
// channel does not stall; the sequencer state updates as an item leaves the
// input register. Synchronous active-high reset clears pending state, the counter
// and the stored values, and loads the timeout register with 500 ms.
// ----------------------------------------------------------------------------
module rh_temp_sensor_readout
   import rhts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic               req_kind,
   input  logic               req_read_ok,
   input  logic [7:0]         req_data_high,
   input  logic [7:0]         req_data_low,
   input  logic [7:0]         req_crc_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_command_issued,
   output logic               rsp_command_kind,
   output logic               rsp_value_ready,
   output logic               rsp_crc_error,
   output logic               rsp_timed_out,
   output logic signed [14:0] rsp_temperature_centi,
   output logic signed [14:0] rsp_humidity_centi
);

   logic [15:0]        timeout_ff;
   logic               s1_valid_ff;
   stage_type          s1_ff;
   stage_type          s1_in;
   logic               rsp_valid_ff;
   flags_type          flags_ff;
   flags_type          flags_in;
   logic [1:0]         pend_ff;
   logic [1:0]         pend_in;
   logic [15:0]        elapsed_ff;
   logic [15:0]        elapsed_in;
   logic signed [14:0] temp_ff;
   logic signed [14:0] temp_in;
   logic signed [14:0] hum_ff;
   logic signed [14:0] hum_in;

   logic               out_free;
   logic               advance;
   logic               req_take;
   logic [15:0]        raw;
   logic [30:0]        temp_prod;
   logic [30:0]        hum_prod;
   logic [1:0]         pend_poll;

   // handshake: the result register frees as its beat is taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // front end: checksum and scaling depend on the frame alone
   assign raw       = {req_data_high, req_data_low} & ~STATUS_MASK;
   assign temp_prod = 31'(TEMP_SCALE) * 31'(raw) + ROUND_HALF;
   assign hum_prod  = 31'(HUM_SCALE) * 31'(raw) + ROUND_HALF;

   always_comb begin
      s1_in.opcode   = req_opcode;
      s1_in.kind     = req_kind;
      s1_in.read_ok  = req_read_ok;
      s1_in.crc_ok   = (crc8_frame({req_data_high, req_data_low}) == req_crc_byte);
      s1_in.temp_val = temp_prod[30:16] - TEMP_OFFSET;
      s1_in.hum_val  = hum_prod[30:16] - HUM_OFFSET;
   end

   // sequencer: state update and result for the item leaving stage one
   always_comb begin
      pend_in    = pend_ff;
      elapsed_in = elapsed_ff;
      temp_in    = temp_ff;
      hum_in     = hum_ff;
      flags_in   = '0;
      pend_poll  = pend_ff;
      if (advance) begin
         case (s1_ff.opcode)
            OP_START: begin
               elapsed_in = '0;
               if (pend_ff == PEND_NONE) begin
                  flags_in.command_issued = 1'b1;
                  flags_in.command_kind   = s1_ff.kind;
                  pend_in = (s1_ff.kind == KIND_TEMP) ? PEND_TEMP : PEND_HUM;
               end
            end
            OP_POLL: begin
               if (pend_ff != PEND_NONE && s1_ff.read_ok) begin
                  if (s1_ff.crc_ok) begin
                     if (pend_ff == PEND_TEMP) begin
                        temp_in = s1_ff.temp_val;
                        flags_in.value_ready = 1'b1;
                     end else if (pend_ff == PEND_HUM) begin
                        hum_in = s1_ff.hum_val;
                        flags_in.value_ready = 1'b1;
                     end
                     pend_poll = PEND_NONE;
                  end else begin
                     flags_in.crc_error = 1'b1;
                  end
               end
               pend_in = pend_poll;
               // timeout check after the frame step
               if (elapsed_ff >= timeout_ff) begin
                  flags_in.timed_out = (pend_poll != PEND_NONE);
                  pend_in    = PEND_NONE;
                  elapsed_in = '0;
               end
            end
            OP_TICK: begin
               if (elapsed_ff != ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= PEND_NONE;
         elapsed_ff   <= '0;
         temp_ff      <= '0;
         hum_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         pend_ff    <= pend_in;
         elapsed_ff <= elapsed_in;
         temp_ff    <= temp_in;
         hum_ff     <= hum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         flags_ff <= flags_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_command_issued    = flags_ff.command_issued;
   assign rsp_command_kind      = flags_ff.command_kind;
   assign rsp_value_ready       = flags_ff.value_ready;
   assign rsp_crc_error         = flags_ff.crc_error;
   assign rsp_timed_out         = flags_ff.timed_out;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;

   // checks
   a_pend_code: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("pending code out of range");

   a_issue_sets_pend: assert property (@(posedge clock) disable iff (reset)
      advance && flags_in.command_issued |=> pend_ff != PEND_NONE)
      else $error("command issued without pending measurement");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      advance && flags_in.timed_out |=> pend_ff == PEND_NONE && elapsed_ff == 16'd0)
      else $error("timeout did not clear state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_issued |-> !rsp_value_ready && !rsp_crc_error && !rsp_timed_out)
      else $error("start result carries poll flags");

endmodule

FILE: verif/rh_temp_sensor_readout_tb.sv
// ----------------------------------------------------------------------------
// rh_temp_sensor_readout_tb - self-checking bench for the sensor readout
// Drives start, poll and tick events with random idle and back-pressure on
// both channels. A scoreboard tracks pending kind, millisecond counter and
// stored values, predicts every result beat, and compares each field in
// order. The timeout register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module rh_temp_sensor_readout_tb
   import rhts_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // opcode three has no package name; the block ignores it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // one result beat as seen on the rsp_ ports
   typedef struct packed {
      flags_type          flags;
      logic signed [14:0] temp;
      logic signed [14:0] hum;
   } readout_beat_type;

   // -------------------------------------------------------------------------
   // scoreboard: sequencer state mirror and queue of expected result beats
   // -------------------------------------------------------------------------
   class readout_scoreboard;
      logic [15:0]        timeout_val;
      logic [1:0]         pend;
      logic [15:0]        elapsed;
      logic signed [14:0] last_temp;
      logic signed [14:0] last_hum;
      readout_beat_type   expected_q[$];
      int                 errors;

      function new();
         timeout_val = TIMEOUT_RESET;
         pend        = PEND_NONE;
         elapsed     = '0;
         last_temp   = '0;
         last_hum    = '0;
         errors      = 0;
      endfunction

      // CRC-8, poly 0x31, init 0, MSB first, byte at a time
      function logic [7:0] checksum(logic [7:0] hi, logic [7:0] lo);
         logic [7:0] crc;
         crc = 8'h00;
         for (int n = 0; n < 2; n++) begin
            crc = crc ^ ((n == 0) ? hi : lo);
            for (int k = 0; k < 8; k++) begin
               if (crc[7]) begin
                  crc = {crc[6:0], 1'b0} ^ CRC_POLY;
               end else begin
                  crc = {crc[6:0], 1'b0};
               end
            end
         end
         return crc;
      endfunction

      // status bits cleared, scaled, rounded half up, offset removed
      function logic signed [14:0] to_centi(logic [7:0] hi, logic [7:0] lo,
                                            logic [15:0] scale, logic [14:0] offset);
         logic [15:0] raw;
         logic [31:0] prod;
         int          val;
         raw  = {hi, lo} & ~STATUS_MASK;
         prod = 32'(scale) * 32'(raw) + 32'(ROUND_HALF);
         val  = int'(prod[31:16]) - int'(offset);
         return val[14:0];
      endfunction

      function int expected_count();
         return expected_q.size();
      endfunction

      // accepted request beat: advance the mirror and queue its result
      function void note_input(logic [1:0] op, logic kind, logic ok,
                               logic [7:0] hi, logic [7:0] lo, logic [7:0] crc);
         readout_beat_type want;
         want.flags = '0;
         case (op)
            OP_START: begin
               elapsed = '0;
               if (pend == PEND_NONE) begin
                  want.flags.command_issued = 1'b1;
                  want.flags.command_kind   = kind;
                  pend = (kind == KIND_TEMP) ? PEND_TEMP : PEND_HUM;
               end
            end
            OP_POLL: begin
               if (pend != PEND_NONE && ok) begin
                  if (checksum(hi, lo) == crc) begin
                     if (pend == PEND_TEMP) begin
                        last_temp = to_centi(hi, lo, 16'(TEMP_SCALE), TEMP_OFFSET);
                     end else begin
                        last_hum = to_centi(hi, lo, 16'(HUM_SCALE), HUM_OFFSET);
                     end
                     want.flags.value_ready = 1'b1;
                     pend = PEND_NONE;
                  end else begin
                     want.flags.crc_error = 1'b1;
                  end
               end
               // timeout check comes after the frame step
               if (elapsed >= timeout_val) begin
                  if (pend != PEND_NONE) want.flags.timed_out = 1'b1;
                  pend    = PEND_NONE;
                  elapsed = '0;
               end
            end
            OP_TICK: begin
               if (elapsed != ELAPSED_MAX) elapsed = elapsed + 16'd1;
            end
            default: ;
         endcase
         want.temp = last_temp;
         want.hum  = last_hum;
         expected_q.push_back(want);
      endfunction

      task report(string msg);
         errors++;
         $display("tb: mismatch at %0t: %s", $realtime, msg);
      endtask

      task cmp(string name, logic signed [15:0] got, logic signed [15:0] want);
         if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      // accepted result beat: compare against the oldest expectation
      task check_result(readout_beat_type got);
         readout_beat_type want;
         if (expected_q.size() == 0) begin
            report("result beat with nothing expected");
            return;
         end
         want = expected_q.pop_front();
         cmp("command_issued", 16'(got.flags.command_issued), 16'(want.flags.command_issued));
         cmp("command_kind",   16'(got.flags.command_kind),   16'(want.flags.command_kind));
         cmp("value_ready",    16'(got.flags.value_ready),    16'(want.flags.value_ready));
         cmp("crc_error",      16'(got.flags.crc_error),      16'(want.flags.crc_error));
         cmp("timed_out",      16'(got.flags.timed_out),      16'(want.flags.timed_out));
         cmp("temperature_centi", got.temp, want.temp);
         cmp("humidity_centi",    got.hum,  want.hum);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // signals
   // -------------------------------------------------------------------------
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               csr_valid     = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_data      = '0;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode    = '0;
   logic               req_kind      = 1'b0;
   logic               req_read_ok   = 1'b0;
   logic [7:0]         req_data_high = '0;
   logic [7:0]         req_data_low  = '0;
   logic [7:0]         req_crc_byte  = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic               rsp_command_issued;
   logic               rsp_command_kind;
   logic               rsp_value_ready;
   logic               rsp_crc_error;
   logic               rsp_timed_out;
   logic signed [14:0] rsp_temperature_centi;
   logic signed [14:0] rsp_humidity_centi;

   readout_scoreboard  sb = new();
   bit                 steady = 1'b0;   // no idling on either side when set
   int                 item_count = 0;

   rh_temp_sensor_readout dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_kind              (req_kind),
      .req_read_ok           (req_read_ok),
      .req_data_high         (req_data_high),
      .req_data_low          (req_data_low),
      .req_crc_byte          (req_crc_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_command_issued    (rsp_command_issued),
      .rsp_command_kind      (rsp_command_kind),
      .rsp_value_ready       (rsp_value_ready),
      .rsp_crc_error         (rsp_crc_error),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi)
   );

   always #5 clock = ~clock;

   // result side back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && !steady && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      readout_beat_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.flags.command_issued = rsp_command_issued;
         got.flags.command_kind   = rsp_command_kind;
         got.flags.value_ready    = rsp_value_ready;
         got.flags.crc_error      = rsp_crc_error;
         got.flags.timed_out      = rsp_timed_out;
         got.temp                 = rsp_temperature_centi;
         got.hum                  = rsp_humidity_centi;
         sb.check_result(got);
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------

   // one request beat; optional idle burst once it has gone in
   task automatic send(logic [1:0] op, logic kind, logic ok,
                       logic [7:0] hi, logic [7:0] lo, logic [7:0] crc);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_kind      <= kind;
      req_read_ok   <= ok;
      req_data_high <= hi;
      req_data_low  <= lo;
      req_crc_byte  <= crc;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_input(op, kind, ok, hi, lo, crc);
      item_count++;
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // empty the pipe, then let the last beat clear the registers
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // timeout register write, only from idle
   task automatic write_timeout(logic [15:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.timeout_val = val;
   endtask

   task automatic send_tick();
      send(OP_TICK, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_start(logic kind);
      send(OP_START, kind, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // poll with a frame that passes the checksum
   task automatic send_good(logic [7:0] hi, logic [7:0] lo);
      send(OP_POLL, 1'($urandom), 1'b1, hi, lo, sb.checksum(hi, lo));
   endtask

   // start, some ticks, one or two polls; sometimes a lone random event
   task automatic random_sequence();
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] crc;
      logic       ok;
      if ($urandom_range(0, 9) < 7) begin
         send_start(1'($urandom));
         repeat ($urandom_range(0, 8)) send_tick();
         repeat ($urandom_range(1, 2)) begin
            hi  = 8'($urandom);
            lo  = 8'($urandom);
            ok  = ($urandom_range(0, 7) != 0);
            crc = ($urandom_range(0, 4) != 0) ? sb.checksum(hi, lo) : 8'($urandom);
            send(OP_POLL, 1'($urandom), ok, hi, lo, crc);
         end
      end else begin
         send(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic random_phase(logic [15:0] tmo, int n);
      int stop_at;
      write_timeout(tmo);
      stop_at = item_count + n;
      while (item_count < stop_at) random_sequence();
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [7:0] good;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset timeout
      send(OP_POLL, 1'b1, 1'b1, 8'h12, 8'h34, 8'h00);     // nothing pending
      send(OP_UNUSED, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);   // ignored opcode
      send_start(KIND_TEMP);
      send_start(1'b1);                                   // start while pending
      good = sb.checksum(8'hFF, 8'hFF);
      send(OP_POLL, 1'b0, 1'b0, 8'hFF, 8'hFF, good);      // failed read
      send(OP_POLL, 1'b0, 1'b1, 8'hFF, 8'hFF, ~good);     // checksum error
      send_good(8'hFF, 8'hFF);                            // top temperature
      send_start(1'b1);
      send_good(8'h00, 8'h00);                            // bottom humidity
      send_start(KIND_TEMP);
      send_good(8'h00, 8'h00);                            // bottom temperature
      send_start(1'b1);
      send_good(8'hFF, 8'hFF);                            // top humidity
      send_start(KIND_TEMP);
      send_good(8'h66, 8'h53);                            // status bits set

      // directed, shortest timeout
      write_timeout(16'd1);
      send_start(1'b1);
      send_tick();
      send(OP_POLL, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);     // dropped by timeout
      send_tick();
      send(OP_POLL, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);     // restart, none pending
      send_start(KIND_TEMP);
      send_tick();
      send_good(8'h80, 8'h01);                            // value wins over timeout
      send_start(1'b1);
      send_tick();
      send(OP_POLL, 1'b0, 1'b1, 8'h40, 8'h02, 8'h55);     // bad frame and timeout

      // directed, longest timeout: a pending measurement survives the poll
      write_timeout(16'hFFFF);
      send_start(KIND_TEMP);
      repeat (20) send_tick();
      send(OP_POLL, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);

      // random phases over several timeout settings
      random_phase(16'd1, 200);
      random_phase(16'($urandom_range(3, 12)), 200);
      random_phase(TIMEOUT_RESET, 200);
      random_phase(16'hFFFF, 150);
      random_phase(16'($urandom_range(1, 40)), 200);
      steady = 1'b1;
      random_phase(16'($urandom_range(2, 6)), 250);

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_count() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
hdl/rhts_pkg.sv
hdl/rh_temp_sensor_readout.sv
verif/rh_temp_sensor_readout_tb.sv
